// ----- design/plmi_pkg.sv -----
package plmi_pkg;

    localparam int FIELD_W     = 32;
    localparam int PROD_W      = 64;
    localparam int ACC_W       = 64;
    localparam int VALUE_W     = 32;
    localparam int OUT_INDEX_W = 16;
    localparam int EXP_W       = 6;
    localparam int DIV_STEPS   = 64;

    localparam logic signed [ACC_W-1:0]   ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [0:0] {
        OP_CELL,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              term;
        logic              last;
        logic              psum_zero;
        logic [PROD_W-1:0] prod_num;
        logic [PROD_W-1:0] prod_den;
        logic [FIELD_W-1:0] cnt;
        logic [FIELD_W-1:0] psum;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG_NUM,
        ST_LOG_DEN,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// ----- design/plmi_fifo.sv -----
module plmi_fifo
    import plmi_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/plmi_front.sv -----
module plmi_front
    import plmi_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [FIELD_W-1:0] cfg_write_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [FIELD_W-1:0] cell_count,
    input  logic [FIELD_W-1:0] viewpoint_sum,
    input  logic [FIELD_W-1:0] polygon_sum,
    input  logic               last_viewpoint,
    output logic               push,
    output entry_t             push_entry,
    input  logic               fifo_full
);

    localparam int PW = 2 * COUNT_BITS;

    logic [COUNT_BITS-1:0] total_reg;
    logic                  stg_valid_reg;
    logic                  stg_kind_reg;
    logic [COUNT_BITS-1:0] stg_cnt_reg;
    logic [COUNT_BITS-1:0] stg_vsum_reg;
    logic [COUNT_BITS-1:0] stg_psum_reg;
    logic                  stg_last_reg;
    logic [PW-1:0]         prod_num;
    logic [PW-1:0]         prod_den;
    logic                  accept;

    assign push     = stg_valid_reg && !fifo_full;
    assign in_ready = !stg_valid_reg || !fifo_full;
    assign accept   = in_valid && in_ready;

    assign prod_num = PW'(stg_cnt_reg) * PW'(total_reg);
    assign prod_den = PW'(stg_vsum_reg) * PW'(stg_psum_reg);

    always_comb
    begin
        push_entry.op        = stg_kind_reg ? OP_FINISH : OP_CELL;
        push_entry.term      = (stg_cnt_reg != '0) && (stg_vsum_reg != '0)
                               && (stg_psum_reg != '0) && (total_reg != '0);
        push_entry.last      = stg_last_reg;
        push_entry.psum_zero = (stg_psum_reg == '0);
        push_entry.prod_num  = PROD_W'(prod_num);
        push_entry.prod_den  = PROD_W'(prod_den);
        push_entry.cnt       = FIELD_W'(stg_cnt_reg);
        push_entry.psum      = FIELD_W'(stg_psum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                total_reg <= cfg_write_data[COUNT_BITS-1:0];
            end
            if (accept)
            begin
                stg_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                stg_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_kind_reg <= kind;
            stg_cnt_reg  <= cell_count[COUNT_BITS-1:0];
            stg_vsum_reg <= viewpoint_sum[COUNT_BITS-1:0];
            stg_psum_reg <= polygon_sum[COUNT_BITS-1:0];
            stg_last_reg <= last_viewpoint;
        end
    end

endmodule

// ----- design/plmi_log2.sv -----
module plmi_log2
    import plmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [PROD_W-1:0]          x,
    output logic                       busy,
    output logic                       done,
    output logic [EXP_W+FRAC_BITS-1:0] result
);

    localparam int STEP_W = $clog2(FRAC_BITS + 1);

    logic                 busy_reg;
    logic                 sqr_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [2:0]           norm_k_reg;
    logic [PROD_W-1:0]    xs_reg;
    logic [EXP_W-1:0]     lz_reg;
    logic [EXP_W-1:0]     exp_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [31:0]          m_reg;
    logic                 top_zero;
    logic [EXP_W-1:0]     shamt;
    logic [PROD_W-1:0]    xs_next;
    logic [EXP_W-1:0]     lz_next;
    logic [63:0]          sq;
    logic                 sq_bit;
    logic [31:0]          m_next;

    always_comb
    begin
        unique case (norm_k_reg)
            3'd5:    top_zero = (xs_reg[63:32] == '0);
            3'd4:    top_zero = (xs_reg[63:48] == '0);
            3'd3:    top_zero = (xs_reg[63:56] == '0);
            3'd2:    top_zero = (xs_reg[63:60] == '0);
            3'd1:    top_zero = (xs_reg[63:62] == '0);
            default: top_zero = !xs_reg[63];
        endcase
        shamt   = EXP_W'(1) << norm_k_reg;
        xs_next = top_zero ? (xs_reg << shamt) : xs_reg;
        lz_next = top_zero ? (lz_reg + shamt) : lz_reg;
        sq      = 64'(m_reg) * 64'(m_reg);
        sq_bit  = sq[63];
        m_next  = sq_bit ? sq[63:32] : sq[62:31];
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = {exp_reg, frac_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sqr_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                sqr_reg  <= 1'b0;
            end
            else if (busy_reg && !sqr_reg && norm_k_reg == 3'd0)
            begin
                sqr_reg <= 1'b1;
            end
            else if (busy_reg && sqr_reg && step_reg == STEP_W'(FRAC_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xs_reg     <= x;
            lz_reg     <= '0;
            norm_k_reg <= 3'd5;
            step_reg   <= '0;
        end
        else if (busy_reg && !sqr_reg)
        begin
            xs_reg     <= xs_next;
            lz_reg     <= lz_next;
            norm_k_reg <= norm_k_reg - 1'b1;
            if (norm_k_reg == 3'd0)
            begin
                m_reg   <= xs_next[63:32];
                exp_reg <= EXP_W'(63) - lz_next;
            end
        end
        else if (busy_reg)
        begin
            m_reg    <= m_next;
            frac_reg <= {frac_reg[FRAC_BITS-2:0], sq_bit};
            step_reg <= step_reg + 1'b1;
        end
    end

endmodule

// ----- design/plmi_back.sv -----
module plmi_back
    import plmi_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int INDEX_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  entry_t                        head_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_W-1:0]     value,
    output logic [OUT_INDEX_W-1:0]        polygon_index,
    output logic                          out_of_domain,
    output logic                          is_maximum
);

    localparam int LOG_W  = EXP_W + FRAC_BITS;
    localparam int T_W    = LOG_W + COUNT_BITS;
    localparam int SUM_W  = ACC_W + 2;
    localparam int DSTEP_W = $clog2(DIV_STEPS);

    state_t state_reg;
    state_t state_next;

    entry_t                     entry_reg;
    logic [LOG_W-1:0]           ln_reg;
    logic [LOG_W-1:0]           ld_reg;
    logic [T_W-1:0]             t_reg;
    logic                       t_neg_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [VALUE_W-1:0]  max_reg;
    logic [INDEX_BITS-1:0]      idx_reg;
    logic [COUNT_BITS-1:0]      rem_reg;
    logic [ACC_W-1:0]           dvd_reg;
    logic                       div_neg_reg;
    logic [DSTEP_W-1:0]         dstep_reg;
    logic                       out_valid_reg;
    logic signed [VALUE_W-1:0]  out_value_reg;
    logic [OUT_INDEX_W-1:0]     out_index_reg;
    logic                       out_ood_reg;
    logic                       out_max_reg;

    logic                       log_start;
    logic [PROD_W-1:0]          log_x;
    logic                       log_busy;
    logic                       log_done;
    logic [LOG_W-1:0]           log_result;
    logic                       out_load;
    logic                       div_init;
    logic signed [ACC_W-1:0]    div_src;

    logic signed [LOG_W:0]      d;
    logic [LOG_W-1:0]           d_mag;
    logic signed [SUM_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    acc_sat;
    logic [COUNT_BITS:0]        trial;
    logic                       trial_ge;
    logic [COUNT_BITS:0]        trial_sub;
    logic signed [VALUE_W-1:0]  div_value;
    logic signed [VALUE_W-1:0]  emit_value;

    plmi_log2 #(
        .FRAC_BITS(FRAC_BITS)
    ) u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .busy   (log_busy),
        .done   (log_done),
        .result (log_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_entry.op == OP_FINISH)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (head_entry.term)
                    begin
                        state_next = ST_LOG_NUM;
                    end
                    else if (head_entry.last)
                    begin
                        state_next = head_entry.psum_zero ? ST_EMIT : ST_DIV;
                    end
                end
            end
            ST_LOG_NUM:
            begin
                if (log_done)
                begin
                    state_next = ST_LOG_DEN;
                end
            end
            ST_LOG_DEN:
            begin
                if (log_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = entry_reg.last ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (dstep_reg == DSTEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        log_start = 1'b0;
        log_x     = entry_reg.prod_den;
        out_load  = 1'b0;
        div_init  = 1'b0;
        div_src   = acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop   = head_valid;
                log_x = head_entry.prod_num;
                if (head_valid && head_entry.op == OP_CELL)
                begin
                    log_start = head_entry.term;
                    div_init  = !head_entry.term && head_entry.last && !head_entry.psum_zero;
                end
            end
            ST_LOG_NUM:
            begin
                log_start = log_done;
            end
            ST_ACC:
            begin
                div_init = entry_reg.last;
                div_src  = acc_sat;
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        d         = $signed({1'b0, ln_reg}) - $signed({1'b0, ld_reg});
        d_mag     = d[LOG_W] ? LOG_W'(-d) : LOG_W'(d);
        acc_sum   = t_neg_reg ? (SUM_W'(acc_reg) - $signed(SUM_W'(t_reg)))
                              : (SUM_W'(acc_reg) + $signed(SUM_W'(t_reg)));
        if (acc_sum > SUM_W'(ACC_MAX))
        begin
            acc_sat = ACC_MAX;
        end
        else if (acc_sum < -SUM_W'(ACC_MAX))
        begin
            acc_sat = -ACC_MAX;
        end
        else
        begin
            acc_sat = ACC_W'(acc_sum);
        end
        trial     = {rem_reg, dvd_reg[ACC_W-1]};
        trial_ge  = trial >= (COUNT_BITS + 1)'(entry_reg.psum[COUNT_BITS-1:0]);
        trial_sub = trial - (COUNT_BITS + 1)'(entry_reg.psum[COUNT_BITS-1:0]);
        if (div_neg_reg)
        begin
            div_value = (dvd_reg >= 64'h8000_0000) ? VAL_MIN : -$signed(dvd_reg[VALUE_W-1:0]);
        end
        else
        begin
            div_value = (dvd_reg > 64'h7FFF_FFFF) ? VAL_MAX : $signed(dvd_reg[VALUE_W-1:0]);
        end
        if (entry_reg.op == OP_FINISH)
        begin
            emit_value = max_reg;
        end
        else if (entry_reg.psum_zero)
        begin
            emit_value = '0;
        end
        else
        begin
            emit_value = div_value;
        end
    end

    assign out_valid     = out_valid_reg;
    assign value         = out_value_reg;
    assign polygon_index = out_index_reg;
    assign out_of_domain = out_ood_reg;
    assign is_maximum    = out_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            max_reg       <= VAL_MIN;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ACC)
            begin
                acc_reg <= acc_sat;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= '0;
                if (entry_reg.op == OP_FINISH)
                begin
                    idx_reg <= '0;
                    max_reg <= VAL_MIN;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (!entry_reg.psum_zero && div_value > max_reg)
                    begin
                        max_reg <= div_value;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            entry_reg <= head_entry;
        end
        if (log_done && state_reg == ST_LOG_NUM)
        begin
            ln_reg <= log_result;
        end
        if (log_done && state_reg == ST_LOG_DEN)
        begin
            ld_reg <= log_result;
        end
        if (state_reg == ST_MUL)
        begin
            t_reg     <= T_W'(d_mag) * T_W'(entry_reg.cnt[COUNT_BITS-1:0]);
            t_neg_reg <= d[LOG_W];
        end
        if (div_init)
        begin
            div_neg_reg <= div_src[ACC_W-1];
            dvd_reg     <= div_src[ACC_W-1] ? ACC_W'(-div_src) : ACC_W'(div_src);
            rem_reg     <= '0;
            dstep_reg   <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg   <= trial_ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            dvd_reg   <= {dvd_reg[ACC_W-2:0], trial_ge};
            dstep_reg <= dstep_reg + 1'b1;
        end
        if (out_load)
        begin
            out_value_reg <= emit_value;
            out_index_reg <= OUT_INDEX_W'(idx_reg);
            out_ood_reg   <= (entry_reg.op == OP_CELL) && entry_reg.psum_zero;
            out_max_reg   <= (entry_reg.op == OP_FINISH);
        end
    end

    a_log_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        log_start |-> !log_busy)
        else $error("log unit started while busy");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !entry_reg.psum_zero)
        else $error("divide entered with zero polygon sum");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result beat overwritten");

    a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg != {1'b1, {(ACC_W - 1){1'b0}}})
        else $error("accumulator left its saturated range");

endmodule

// ----- design/polygon_mutual_information_top.sv -----
// An accepted beat goes through the front end's staging register and then the queue to the back end.
// A polygon's last cell with no log term gives its result beat after the divider steps and the emit
// state; a log term first goes through the shared iterative log2 unit, numerator then denominator.
// The back end pops a new beat from the queue only when idle, after the previous one is finished.
// Reset clears the queue, the accumulator, the index and total_sum, and sets the maximum
// to the most negative value.
module polygon_mutual_information_top
    import plmi_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int INDEX_BITS = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [FIELD_W-1:0]        cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      kind,
    input  logic [FIELD_W-1:0]        cell_count,
    input  logic [FIELD_W-1:0]        viewpoint_sum,
    input  logic [FIELD_W-1:0]        polygon_sum,
    input  logic                      last_viewpoint,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] value,
    output logic [OUT_INDEX_W-1:0]    polygon_index,
    output logic                      out_of_domain,
    output logic                      is_maximum
);

    localparam int ENTRY_W = $bits(entry_t);

    entry_t push_entry;
    entry_t head_entry;
    logic   push;
    logic   fifo_full;
    logic   pop;
    logic   head_valid;

    plmi_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .cell_count     (cell_count),
        .viewpoint_sum  (viewpoint_sum),
        .polygon_sum    (polygon_sum),
        .last_viewpoint (last_viewpoint),
        .push           (push),
        .push_entry     (push_entry),
        .fifo_full      (fifo_full)
    );

    plmi_fifo #(
        .WIDTH(ENTRY_W),
        .DEPTH(2)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head_data  (head_entry),
        .head_valid (head_valid)
    );

    plmi_back #(
        .COUNT_BITS(COUNT_BITS),
        .INDEX_BITS(INDEX_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .value         (value),
        .polygon_index (polygon_index),
        .out_of_domain (out_of_domain),
        .is_maximum    (is_maximum)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb
    import plmi_pkg::*;
();

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [OUT_INDEX_W-1:0]    polygon_index;
        logic                      out_of_domain;
        logic                      is_maximum;
    } mi_result_t;

    class mi_scoreboard;
        logic [FIELD_W-1:0]        total_sum;
        logic signed [ACC_W-1:0]   acc;
        logic signed [VALUE_W-1:0] best;
        logic [15:0]               poly_idx;
        mi_result_t                expected_q[$];
        int                        errors;

        function new();
            total_sum = '0;
            acc = '0;
            best = VAL_MIN;
            poly_idx = '0;
            errors = 0;
        endfunction

        function longint log2_fx(longint unsigned x);
            int e;
            longint unsigned m;
            longint r;
            e = 63;
            while (e > 0 && x[e] == 1'b0) e--;
            m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
            r = e;
            for (int i = 0; i < 16; i++)
            begin
                m = (m * m) >> 31;
                r = r * 2;
                if (m >= 64'h1_0000_0000)
                begin
                    r = r + 1;
                    m = m >> 1;
                end
            end
            return r;
        endfunction

        function void acc_add(longint t);
            if (t > 0 && acc > ACC_MAX - t) acc = ACC_MAX;
            else if (t < 0 && acc < -ACC_MAX - t) acc = -ACC_MAX;
            else acc = acc + t;
        endfunction

        function logic signed [VALUE_W-1:0] polygon_measure(logic [FIELD_W-1:0] ps);
            logic neg;
            longint unsigned mag;
            longint unsigned q;
            neg = acc < 0;
            mag = neg ? longint'(-acc) : longint'(acc);
            q = mag / longint'(ps);
            if (neg)
            begin
                if (q >= 64'h8000_0000) return VAL_MIN;
                return VALUE_W'(-longint'(q));
            end
            if (q > 64'h7FFF_FFFF) return VAL_MAX;
            return q[31:0];
        endfunction

        function void note_input(op_t op, logic [FIELD_W-1:0] cnt, logic [FIELD_W-1:0] vs,
                                 logic [FIELD_W-1:0] ps, logic last);
            mi_result_t r;
            longint d;
            longint unsigned mag;
            if (op == OP_FINISH)
            begin
                r.value = best;
                r.polygon_index = poly_idx;
                r.out_of_domain = 1'b0;
                r.is_maximum = 1'b1;
                expected_q = {expected_q, r};
                acc = '0;
                poly_idx = '0;
                best = VAL_MIN;
                return;
            end
            if (cnt != 0 && vs != 0 && ps != 0 && total_sum != 0)
            begin
                d = log2_fx(longint'(cnt) * longint'(total_sum))
                    - log2_fx(longint'(vs) * longint'(ps));
                mag = (d < 0 ? -d : d) * longint'(cnt);
                acc_add(d < 0 ? -longint'(mag) : longint'(mag));
            end
            if (!last) return;
            r.polygon_index = poly_idx;
            r.is_maximum = 1'b0;
            if (ps == 0)
            begin
                r.value = '0;
                r.out_of_domain = 1'b1;
            end
            else
            begin
                r.value = polygon_measure(ps);
                r.out_of_domain = 1'b0;
                if (r.value > best) best = r.value;
            end
            expected_q = {expected_q, r};
            acc = '0;
            poly_idx = poly_idx + 1'b1;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(mi_result_t got);
            mi_result_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result value=%h", got.value));
                return;
            end
            e = expected_q.pop_front();
            if (got.value !== e.value)
                report($sformatf("value %h, expected %h", got.value, e.value));
            if (got.polygon_index !== e.polygon_index)
                report($sformatf("polygon_index %0d, expected %0d",
                                 got.polygon_index, e.polygon_index));
            if (got.out_of_domain !== e.out_of_domain)
                report($sformatf("out_of_domain %b, expected %b",
                                 got.out_of_domain, e.out_of_domain));
            if (got.is_maximum !== e.is_maximum)
                report($sformatf("is_maximum %b, expected %b", got.is_maximum, e.is_maximum));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_en;
    logic [FIELD_W-1:0]        cfg_write_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      kind;
    logic [FIELD_W-1:0]        cell_count;
    logic [FIELD_W-1:0]        viewpoint_sum;
    logic [FIELD_W-1:0]        polygon_sum;
    logic                      last_viewpoint;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [VALUE_W-1:0] value;
    logic [OUT_INDEX_W-1:0]    polygon_index;
    logic                      out_of_domain;
    logic                      is_maximum;

    mi_scoreboard sb;
    logic         no_idle;
    logic         hold_req;

    polygon_mutual_information_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .cell_count     (cell_count),
        .viewpoint_sum  (viewpoint_sum),
        .polygon_sum    (polygon_sum),
        .last_viewpoint (last_viewpoint),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .value          (value),
        .polygon_index  (polygon_index),
        .out_of_domain  (out_of_domain),
        .is_maximum     (is_maximum)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    function logic [FIELD_W-1:0] rand_count();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return $urandom_range(1, 16);
            2: return $urandom_range(1, 100000);
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task send_beat(op_t op, logic [FIELD_W-1:0] cnt, logic [FIELD_W-1:0] vs,
                   logic [FIELD_W-1:0] ps, logic last);
        while (!no_idle && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        cell_count <= cnt;
        viewpoint_sum <= vs;
        polygon_sum <= ps;
        last_viewpoint <= last;
        do @(posedge clk); while (!in_ready);
        sb.note_input(op, cnt, vs, ps, last);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task write_total(logic [FIELD_W-1:0] t);
        cfg_write_en <= 1'b1;
        cfg_write_data <= t;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.total_sum = t;
    endtask

    task random_polygon();
        int n;
        logic [FIELD_W-1:0] ps;
        logic [FIELD_W-1:0] c;
        n = $urandom_range(1, 6);
        ps = ($urandom_range(0, 19) == 0) ? '0 : rand_count();
        for (int i = 0; i < n; i++)
        begin
            c = rand_count();
            if ($urandom_range(0, 9) == 0)
                send_beat(OP_CELL, c, rand_count(), rand_count(), 1'b0);
            else
                send_beat(OP_CELL, c, rand_count(), ps, i == n - 1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int hold_cnt;
        mi_result_t got;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.value = value;
                got.polygon_index = polygon_index;
                got.out_of_domain = out_of_domain;
                got.is_maximum = is_maximum;
                sb.check_result(got);
            end
            if (hold_req && hold_cnt == 0) hold_cnt = 3000;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_idle || ($urandom_range(0, 99) >= 7);
        end
    end

    initial
    begin
        sb = new();
        no_idle = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        kind = 1'b0;
        cell_count = '0;
        viewpoint_sum = '0;
        polygon_sum = '0;
        last_viewpoint = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(OP_FINISH, '0, '0, '0, 1'b0);
        send_beat(OP_CELL, 32'd5, 32'd7, 32'd9, 1'b1);
        drain();

        write_total(32'hFFFF_FFFF);
        send_beat(OP_CELL, 32'hFFFF_FFFF, 32'd1, 32'd1, 1'b0);
        send_beat(OP_CELL, '0, 32'd3, 32'd1, 1'b0);
        send_beat(OP_CELL, 32'd3, '0, 32'd1, 1'b0);
        send_beat(OP_CELL, 32'd3, 32'd4, '0, 1'b0);
        send_beat(OP_CELL, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_CELL, 32'd4, 32'd4, '0, 1'b1);
        send_beat(OP_CELL, 32'd1, 32'd2, 32'd3, 1'b1);
        send_beat(OP_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        no_idle = 1'b1;
        for (int i = 0; i < 520; i++)
            send_beat(OP_CELL, 32'hFFFF_FFFF, 32'd1, 32'd1, i == 519);
        no_idle = 1'b0;
        drain();

        write_total(32'd1);
        send_beat(OP_CELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_beat(OP_CELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_FINISH, '0, '0, '0, 1'b0);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            write_total(phase == 0 ? 32'd1000 : (phase == 1 ? $urandom : 32'hFFFF_FFFF));
            for (int p = 0; p < 8; p++)
            begin
                no_idle = (phase == 1 && p >= 2 && p < 6);
                if (phase == 2 && p == 4) hold_req = 1'b1;
                if (phase == 2 && p == 5) hold_req = 1'b0;
                random_polygon();
                if ($urandom_range(0, 9) == 0)
                    send_beat(OP_FINISH, $urandom, $urandom, $urandom, $urandom_range(0, 1));
            end
            no_idle = 1'b0;
            send_beat(OP_FINISH, '0, '0, '0, 1'b0);
            drain();
        end

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
